// ----- hdl/lease_lock_table_defines.svh -----
// Assertion macros shared by the lease lock table RTL.
`ifndef LEASE_LOCK_TABLE_DEFINES_SVH
`define LEASE_LOCK_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LLT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LLT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/llt_pkg.sv -----
// Types, codes and lease arithmetic for the lease lock table.
package llt_pkg;

	localparam logic [1:0] REQ_CLAIM   = 2'd0;
	localparam logic [1:0] REQ_RENEW   = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;
	localparam logic [1:0] REQ_COUNT   = 2'd3;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_CONFLICT = 2'd1;
	localparam logic [1:0] STS_UNAVAIL  = 2'd2;

	localparam logic [15:0] WINDOW_RESET = 16'd2000;
	localparam logic [31:0] STAMP_MAX    = 32'hffff_ffff;
	localparam logic [3:0]  COUNT_MAX    = 4'd15;

	typedef struct packed {
		logic [31:0] owner;
		logic [31:0] stamp;
	} entry_t;

	function automatic logic lease_fresh(entry_t e, logic [31:0] now, logic [15:0] win);
		logic [31:0] age;
		logic [31:0] w;
		age = now - e.stamp;
		w   = {16'd0, win};
		return (e.owner != 32'd0) && ((age <= w) || (age >= (STAMP_MAX - w)));
	endfunction

	function automatic logic lease_touch_ok(entry_t e, logic [31:0] now, logic [15:0] win);
		logic [31:0] age;
		age = now - e.stamp;
		return age < (STAMP_MAX - {16'd0, win});
	endfunction

endpackage

// ----- hdl/lease_lock_table.sv -----
// Lease lock table top level: request sequencer, id counter and result register.
// Usage:
//   Requests enter on req_valid/req_stall with req_type, slot, held_id, now_ms;
//   one result leaves per request on rsp_valid/rsp_stall with status,
//   granted_id, fresh_count. A transfer happens when valid is high, stall low.
//   The window register is written on cfg_valid/cfg_ready (always ready) with
//   cfg_data. The user must write it only while no request is in flight; the
//   block itself does not enforce this.
// Sequence: claim, renew and release pass through slot read, evaluate and
//   write back, and result load; a bad slot goes straight to result load; a
//   count walks the target slots one memory read per cycle, then drains and
//   loads the result. One request is in flight at a time; the next is taken
//   as soon as the sequencer is back in idle, even while a result still waits.
// Reset clears all leases (valid bits), sets the id counter to one and the
//   window to 2000 ms. While rsp_stall is high the result is held and a
//   finished second request waits in the sequencer with req_stall high.
`include "lease_lock_table_defines.svh"

module lease_lock_table #(
	parameter int TARGET_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [3:0]  slot,
	input  logic [31:0] held_id,
	input  logic [31:0] now_ms,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [31:0] granted_id,
	output logic [3:0]  fresh_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int DEPTH = TARGET_SLOTS + 1;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOOK  = 3'd1;
	localparam logic [2:0] ST_EVAL  = 3'd2;
	localparam logic [2:0] ST_WALK  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]  state_q;
	logic [1:0]  type_q;
	logic [AW-1:0] addr_q;
	logic [31:0] held_q;
	logic [31:0] now_q;
	logic [15:0] window_q;
	logic [32:0] next_id_q;
	logic [AW-1:0] idx_q;
	logic        samp_s1;
	logic [3:0]  count_q;
	logic [1:0]  res_status_q;
	logic [31:0] res_granted_q;
	logic        rsp_valid_q;
	logic [1:0]  status_q;
	logic [31:0] granted_q;
	logic [3:0]  fresh_q;

	logic            req_acc;
	logic            bad_slot;
	logic            rsp_load;
	logic            mem_we;
	logic [AW-1:0]   mem_raddr;
	llt_pkg::entry_t mem_wdata;
	llt_pkg::entry_t rd;
	logic            owns;
	logic            fresh;
	logic            touch_ok;

	llt_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (addr_q),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign bad_slot  = 32'(slot) > 32'(TARGET_SLOTS);
	assign cfg_ready = 1'b1;
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
	assign mem_raddr = (state_q == ST_WALK) ? idx_q : addr_q;

	assign owns     = (held_q != 32'd0) && (rd.owner == held_q);
	assign fresh    = llt_pkg::lease_fresh(rd, now_q, window_q);
	assign touch_ok = llt_pkg::lease_touch_ok(rd, now_q, window_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = rd;
		if (state_q == ST_EVAL) begin
			case (type_q)
				llt_pkg::REQ_CLAIM: begin
					if (owns) begin
						mem_we    = touch_ok;
						mem_wdata = '{owner: rd.owner, stamp: now_q};
					end else if (!fresh && !next_id_q[32]) begin
						mem_we    = 1'b1;
						mem_wdata = '{owner: next_id_q[31:0], stamp: now_q};
					end
				end
				llt_pkg::REQ_RENEW: begin
					if (owns) begin
						mem_we    = touch_ok;
						mem_wdata = '{owner: rd.owner, stamp: now_q};
					end
				end
				llt_pkg::REQ_RELEASE: begin
					if (owns) begin
						mem_we    = 1'b1;
						mem_wdata = '0;
					end
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			type_q <= req_type;
			addr_q <= AW'(slot);
			held_q <= held_id;
			now_q  <= now_ms;
		end
		if (rsp_load) begin
			status_q  <= res_status_q;
			granted_q <= res_granted_q;
			fresh_q   <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_q      <= llt_pkg::WINDOW_RESET;
			next_id_q     <= 33'd1;
			idx_q         <= '0;
			samp_s1       <= 1'b0;
			count_q       <= '0;
			res_status_q  <= llt_pkg::STS_OK;
			res_granted_q <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_q <= cfg_data;
			end
			samp_s1 <= (state_q == ST_WALK);
			if (samp_s1 && llt_pkg::lease_fresh(rd, now_q, window_q) &&
			    (count_q != llt_pkg::COUNT_MAX)) begin
				count_q <= count_q + 4'd1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						count_q       <= '0;
						res_status_q  <= llt_pkg::STS_OK;
						res_granted_q <= held_id;
						if (req_type == llt_pkg::REQ_COUNT) begin
							idx_q   <= AW'(1);
							state_q <= ST_WALK;
						end else if (bad_slot) begin
							res_status_q <= llt_pkg::STS_UNAVAIL;
							state_q      <= ST_DONE;
						end else begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					case (type_q)
						llt_pkg::REQ_CLAIM: begin
							if (!owns) begin
								if (fresh) begin
									res_status_q <= llt_pkg::STS_CONFLICT;
								end else if (next_id_q[32]) begin
									res_status_q <= llt_pkg::STS_UNAVAIL;
								end else begin
									res_granted_q <= next_id_q[31:0];
									next_id_q     <= next_id_q + 33'd1;
								end
							end
						end
						llt_pkg::REQ_RENEW: begin
							if (!owns) begin
								res_status_q <= llt_pkg::STS_CONFLICT;
							end
						end
						default: begin
							res_granted_q <= '0;
						end
					endcase
					state_q <= ST_DONE;
				end
				ST_WALK: begin
					if (idx_q == AW'(TARGET_SLOTS)) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign granted_id  = granted_q;
	assign fresh_count = fresh_q;

	`LLT_ASSERT_NOW(a_id_saturates, next_id_q[32], next_id_q[31:0] == 32'd0,
		"owner id counter ran past its limit")
	`LLT_ASSERT_NOW(a_walk_in_range, state_q == ST_WALK,
		(idx_q != '0) && (32'(idx_q) <= 32'(TARGET_SLOTS)),
		"count walk outside the target slots")
	`LLT_ASSERT_NEXT(a_eval_to_done, state_q == ST_EVAL, state_q == ST_DONE,
		"evaluate step did not hand over to result load")
	`LLT_ASSERT_NOW(a_rsp_from_done, $rose(rsp_valid_q), $past(state_q) == ST_DONE,
		"result raised outside result load")

endmodule

// ----- hdl/llt_mem.sv -----
// Lease entry memory: one write port, one registered read port, per-entry valid bits.
module llt_mem #(
	parameter int DEPTH = 9,
	parameter int AW    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  llt_pkg::entry_t      wdata,
	input  logic [AW-1:0]        raddr,
	output llt_pkg::entry_t      rdata
);

	llt_pkg::entry_t mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	llt_pkg::entry_t  rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rd_vld_q <= vld_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

// ----- sim/lease_lock_table_tb.sv -----
// Self-checking testbench for the lease lock table: directed and random lease requests.
module lease_lock_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TARGET_SLOTS = 8;
	localparam int CLK_PERIOD   = 20;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE       = TARGET_SLOTS + 12;
	localparam int HOLD_AT      = 200;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 200;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic [31:0] held;
		logic [31:0] now;
	} lease_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] granted;
		logic [3:0]  count;
	} lease_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  req_type = llt_pkg::REQ_COUNT;
	logic [3:0]  slot = 4'd0;
	logic [31:0] held_id = 32'd0;
	logic [31:0] now_ms = 32'd0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] granted_id;
	logic [3:0]  fresh_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'd0;

	logic [31:0] own_id [0:TARGET_SLOTS];
	logic [31:0] own_stamp [0:TARGET_SLOTS];
	logic [32:0] id_next;
	logic [15:0] window_ms;

	lease_req_t   request_backlog[$];
	lease_reply_t reply_due[$];
	int           issued_total = 0;
	int           accepted_total = 0;
	int           window_writes = 0;
	int           error_count = 0;
	int           cycle_count = 0;
	int           send_gap = 0;
	int           stall_left = 0;
	int           hold_left = 0;
	logic         hold_done = 1'b0;
	logic         req_fire = 1'b0;
	logic         calm = 1'b0;
	logic [31:0]  clock_ms = 32'd0;

	lease_lock_table #(
		.TARGET_SLOTS(TARGET_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.slot(slot),
		.held_id(held_id),
		.now_ms(now_ms),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.granted_id(granted_id),
		.fresh_count(fresh_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic lease_live(int s, logic [31:0] now);
		logic [31:0] age;
		logic [31:0] w;
		age = now - own_stamp[s];
		w = {16'd0, window_ms};
		return own_id[s] != 32'd0 && (age <= w || age >= llt_pkg::STAMP_MAX - w);
	endfunction

	function automatic void refresh_stamp(int s, logic [31:0] now);
		logic [31:0] age;
		age = now - own_stamp[s];
		if (age < llt_pkg::STAMP_MAX - {16'd0, window_ms})
			own_stamp[s] = now;
	endfunction

	function automatic lease_reply_t apply_lease_request(lease_req_t rq);
		lease_reply_t rp;
		int s;
		int i;
		rp.status = llt_pkg::STS_OK;
		rp.granted = rq.held;
		rp.count = 4'd0;
		s = int'(rq.slot);
		if (rq.kind == llt_pkg::REQ_COUNT) begin
			for (i = 1; i <= TARGET_SLOTS; i++)
				if (lease_live(i, rq.now) && rp.count != llt_pkg::COUNT_MAX)
					rp.count++;
		end else if (s > TARGET_SLOTS) begin
			rp.status = llt_pkg::STS_UNAVAIL;
		end else if (rq.kind == llt_pkg::REQ_CLAIM) begin
			if (rq.held != 32'd0 && own_id[s] == rq.held) begin
				refresh_stamp(s, rq.now);
			end else if (lease_live(s, rq.now)) begin
				rp.status = llt_pkg::STS_CONFLICT;
			end else if (id_next > {1'b0, llt_pkg::STAMP_MAX}) begin
				rp.status = llt_pkg::STS_UNAVAIL;
			end else begin
				rp.granted = id_next[31:0];
				id_next++;
				own_id[s] = rp.granted;
				own_stamp[s] = rq.now;
			end
		end else if (rq.kind == llt_pkg::REQ_RENEW) begin
			if (rq.held == 32'd0 || own_id[s] != rq.held)
				rp.status = llt_pkg::STS_CONFLICT;
			else
				refresh_stamp(s, rq.now);
		end else begin
			if (rq.held != 32'd0 && own_id[s] == rq.held) begin
				own_id[s] = 32'd0;
				own_stamp[s] = 32'd0;
			end
			rp.granted = 32'd0;
		end
		return rp;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		$display("%0t ns: %s mismatch, got %0h want %0h", $realtime, what, got, want);
	endtask

	// check responses first, then record the request taken at this edge
	always @(posedge clk) begin
		lease_reply_t want;
		lease_req_t rq;
		if (arst_n) begin
			req_fire <= req_valid && !req_stall;
			if (rsp_valid && !rsp_stall) begin
				if (reply_due.size() == 0) begin
					report_mismatch("unrequested response status", 32'(status),
						32'(llt_pkg::STS_OK));
				end else begin
					want = reply_due.pop_front();
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
					if (granted_id !== want.granted)
						report_mismatch("granted_id", granted_id, want.granted);
					if (fresh_count !== want.count)
						report_mismatch("fresh_count", 32'(fresh_count), 32'(want.count));
				end
			end
			if (req_valid && !req_stall) begin
				rq.kind = req_type;
				rq.slot = slot;
				rq.held = held_id;
				rq.now = now_ms;
				reply_due.push_back(apply_lease_request(rq));
				accepted_total++;
			end
			if (cfg_valid && cfg_ready) begin
				window_ms = cfg_data;
				window_writes++;
			end
		end
	end

	// hold each request until taken; insert random gaps between requests
	always @(negedge clk) begin
		lease_req_t rq;
		if (arst_n && (!req_valid || req_fire)) begin
			if (send_gap > 0) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (request_backlog.size() != 0) begin
				rq = request_backlog.pop_front();
				req_valid <= 1'b1;
				req_type <= rq.kind;
				slot <= rq.slot;
				held_id <= rq.held;
				now_ms <= rq.now;
				if (!calm && $urandom_range(0, 9) == 0)
					send_gap = $urandom_range(1, 19);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && accepted_total >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (!calm && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 19);
		rsp_stall <= stall_left != 0 || hold_left != 0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic queue_req(input logic [1:0] kind, input logic [3:0] s,
			input logic [31:0] held, input logic [31:0] now);
		lease_req_t rq;
		rq.kind = kind;
		rq.slot = s;
		rq.held = held;
		rq.now = now;
		request_backlog.push_back(rq);
		issued_total++;
	endtask

	task automatic wait_quiet();
		do
			@(negedge clk);
		while (request_backlog.size() != 0 || accepted_total != issued_total ||
				reply_due.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_window(input logic [15:0] w);
		int seen;
		wait_quiet();
		seen = window_writes;
		cfg_valid <= 1'b1;
		cfg_data <= w;
		do
			@(negedge clk);
		while (window_writes == seen);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_random(input int n);
		int k;
		int r;
		int s;
		logic [1:0] kind;
		logic [3:0] pick;
		logic [31:0] held;
		logic [31:0] now;
		logic [31:0] w;
		for (k = 0; k < n; k++) begin
			while (request_backlog.size() >= 2)
				@(negedge clk);
			w = {16'd0, window_ms};
			r = $urandom_range(0, 99);
			kind = r < 40 ? llt_pkg::REQ_CLAIM : r < 65 ? llt_pkg::REQ_RENEW :
				r < 82 ? llt_pkg::REQ_RELEASE : llt_pkg::REQ_COUNT;
			if ($urandom_range(0, 19) == 0)
				pick = 4'($urandom_range(TARGET_SLOTS + 1, 15));
			else
				pick = 4'($urandom_range(0, TARGET_SLOTS));
			s = pick <= TARGET_SLOTS ? int'(pick) : 1;
			r = $urandom_range(0, 99);
			if (r < 50 && pick <= TARGET_SLOTS)
				held = own_id[pick];
			else if (r < 68)
				held = 32'd0;
			else if (r < 85)
				held = id_next[31:0] - $urandom_range(1, 12);
			else
				held = $urandom;
			r = $urandom_range(0, 99);
			if (r < 65) begin
				clock_ms += $urandom_range(0, w / 8 + 3);
				now = clock_ms;
			end else if (r < 80) begin
				clock_ms += $urandom_range(w / 2, w + w / 2 + 2);
				now = clock_ms;
			end else if (r < 88) begin
				now = clock_ms - $urandom_range(0, w + 3);
			end else if (r < 95) begin
				// land on either side of the window edge, past or future
				if ($urandom_range(0, 1))
					now = own_stamp[s] + w + $urandom_range(0, 1);
				else
					now = own_stamp[s] - w - 1 - $urandom_range(0, 1);
			end else begin
				clock_ms = $urandom;
				now = clock_ms;
			end
			queue_req(kind, pick, held, now);
		end
	endtask

	initial begin
		int i;
		for (i = 0; i <= TARGET_SLOTS; i++) begin
			own_id[i] = 32'd0;
			own_stamp[i] = 32'd0;
		end
		id_next = 33'd1;
		window_ms = llt_pkg::WINDOW_RESET;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ids are handed out in order from one
		queue_req(llt_pkg::REQ_CLAIM, 4'd0, 32'd0, 32'd100);
		queue_req(llt_pkg::REQ_CLAIM, 4'd8, 32'd0, 32'd100);
		queue_req(llt_pkg::REQ_CLAIM, 4'd8, 32'd5, 32'd2100);
		queue_req(llt_pkg::REQ_RENEW, 4'd8, 32'd2, 32'd50);
		queue_req(llt_pkg::REQ_CLAIM, 4'd8, 32'd2, 32'd1000);
		queue_req(llt_pkg::REQ_RENEW, 4'd8, 32'd0, 32'd1000);
		queue_req(llt_pkg::REQ_CLAIM, 4'd8, 32'd0, 32'd3001);
		queue_req(llt_pkg::REQ_CLAIM, 4'd0, 32'd0, 32'd100 - 32'd2001);
		queue_req(llt_pkg::REQ_CLAIM, 4'd0, 32'd0, 32'd100 - 32'd2002);
		queue_req(llt_pkg::REQ_RELEASE, 4'd0, 32'd3, 32'd200);
		queue_req(llt_pkg::REQ_RELEASE, 4'd0, 32'd4, 32'd200);
		queue_req(llt_pkg::REQ_RELEASE, 4'd0, 32'd0, 32'd200);
		queue_req(llt_pkg::REQ_CLAIM, 4'd9, 32'd0, 32'd0);
		queue_req(llt_pkg::REQ_RENEW, 4'hf, 32'hffff_ffff, 32'hffff_ffff);
		queue_req(llt_pkg::REQ_RELEASE, 4'd12, 32'd3, 32'd0);
		queue_req(llt_pkg::REQ_CLAIM, 4'd1, 32'd0, 32'hffff_ffff);
		queue_req(llt_pkg::REQ_CLAIM, 4'd1, 32'd5, 32'd0);
		queue_req(llt_pkg::REQ_COUNT, 4'd0, 32'd0, 32'd0);
		queue_req(llt_pkg::REQ_RENEW, 4'd1, 32'd5, 32'h7fff_ffff);
		for (i = 2; i < TARGET_SLOTS; i++)
			queue_req(llt_pkg::REQ_CLAIM, 4'(i), 32'd0, 32'h7fff_ffff);
		queue_req(llt_pkg::REQ_COUNT, 4'd3, 32'd9, 32'h7fff_ffff);
		queue_req(llt_pkg::REQ_CLAIM, 4'd8, 32'd0, 32'h7fff_ffff);
		queue_req(llt_pkg::REQ_COUNT, 4'hf, 32'hffff_ffff, 32'h7fff_ffff);

		set_window(16'hffff);
		queue_random(PHASE_ITEMS);
		set_window(16'd0);
		queue_random(PHASE_ITEMS);
		set_window(16'd1);
		queue_random(PHASE_ITEMS);
		set_window(16'($urandom_range(2, 65534)));
		queue_random(PHASE_ITEMS);
		set_window(16'd50);
		queue_random(PHASE_ITEMS);
		set_window(llt_pkg::WINDOW_RESET);
		calm = 1'b1;
		queue_random(PHASE_ITEMS);

		wait_quiet();
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/llt_pkg.sv
hdl/llt_mem.sv
hdl/lease_lock_table.sv
sim/lease_lock_table_tb.sv
